// File: rtl/core/ela_pkg.sv
// ----------------------------------------------------------------------------
// ela_pkg
// shared widths, constants and the sequencer microcode for the echo level
// averager
// ----------------------------------------------------------------------------
package ela_pkg;

    // default ring depth
    localparam int AVG_DEPTH_DEF = 8;

    // field widths
    localparam int ECHO_W  = 16;
    localparam int DIST_W  = 17;
    localparam int PCT_W   = 15;
    localparam int TANK_W  = 9;
    localparam int OFFS_W  = 7;
    localparam int CFG_W   = 9;

    // register index port
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TANK_HEIGHT   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_OFFSET = 1'b1;

    // register reset values
    localparam logic [TANK_W-1:0] TANK_RESET = 9'd200;
    localparam logic [OFFS_W-1:0] OFFS_RESET = 7'd0;

    // microseconds to q8 centimetres: echo * 4496 >> 10
    localparam int US_MUL_W = 13;
    localparam logic [US_MUL_W-1:0] US_TO_Q8_MUL = 13'd4496;
    localparam int US_SHIFT = 10;
    localparam int PROD_W   = ECHO_W + US_MUL_W;
    localparam int RAW_W    = PROD_W - US_SHIFT;

    // span (tank + offset) in q8
    localparam int SPAN_W   = TANK_W + 1 + 8;

    localparam logic [DIST_W-1:0] DIST_MAX   = 17'h1FFFF;
    localparam logic [DIST_W-1:0] MEAN_RESET = 17'd25600;
    localparam logic [PCT_W-1:0]  PCT_MAX    = 15'd25600;

    // percent scale
    localparam int PCT_SCALE_W = 7;
    localparam logic [PCT_SCALE_W-1:0] PCT_SCALE = 7'd100;
    localparam int PCT_PROD_W = DIST_W + PCT_SCALE_W;

    // sequencer
    localparam int PC_W = 4;
    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [3:0] {
        OP_WAIT,
        OP_MUL,
        OP_CLAMP,
        OP_ACCUM,
        OP_DIV_MEAN,
        OP_DIV_RUN,
        OP_MEAN,
        OP_LEVEL,
        OP_MUL_PCT,
        OP_DIV_PCT,
        OP_PCT,
        OP_EMIT,
        OP_NOP
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_BEAT,
        COND_TIMEOUT,
        COND_DIV_BUSY,
        COND_OUT_BLOCKED
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   target;
    } uword_t;

    localparam pc_t STEP_WAIT     = 4'd0;
    localparam pc_t STEP_MUL      = 4'd1;
    localparam pc_t STEP_CLAMP    = 4'd2;
    localparam pc_t STEP_ACCUM    = 4'd3;
    localparam pc_t STEP_DIV_MEAN = 4'd4;
    localparam pc_t STEP_RUN_MEAN = 4'd5;
    localparam pc_t STEP_MEAN     = 4'd6;
    localparam pc_t STEP_LEVEL    = 4'd7;
    localparam pc_t STEP_MUL_PCT  = 4'd8;
    localparam pc_t STEP_DIV_PCT  = 4'd9;
    localparam pc_t STEP_RUN_PCT  = 4'd10;
    localparam pc_t STEP_PCT      = 4'd11;
    localparam pc_t STEP_EMIT     = 4'd12;
    localparam pc_t STEP_RETURN   = 4'd13;

    // control store: jump to target when the condition holds, else step on
    function automatic uword_t ucode_rom(input pc_t pc);
        uword_t w;
        begin
            case (pc)
                STEP_WAIT:     w = '{OP_WAIT,     COND_NO_BEAT,     STEP_WAIT};
                STEP_MUL:      w = '{OP_MUL,      COND_TIMEOUT,     STEP_LEVEL};
                STEP_CLAMP:    w = '{OP_CLAMP,    COND_NEXT,        STEP_WAIT};
                STEP_ACCUM:    w = '{OP_ACCUM,    COND_NEXT,        STEP_WAIT};
                STEP_DIV_MEAN: w = '{OP_DIV_MEAN, COND_NEXT,        STEP_WAIT};
                STEP_RUN_MEAN: w = '{OP_DIV_RUN,  COND_DIV_BUSY,    STEP_RUN_MEAN};
                STEP_MEAN:     w = '{OP_MEAN,     COND_NEXT,        STEP_WAIT};
                STEP_LEVEL:    w = '{OP_LEVEL,    COND_NEXT,        STEP_WAIT};
                STEP_MUL_PCT:  w = '{OP_MUL_PCT,  COND_NEXT,        STEP_WAIT};
                STEP_DIV_PCT:  w = '{OP_DIV_PCT,  COND_NEXT,        STEP_WAIT};
                STEP_RUN_PCT:  w = '{OP_DIV_RUN,  COND_DIV_BUSY,    STEP_RUN_PCT};
                STEP_PCT:      w = '{OP_PCT,      COND_NEXT,        STEP_WAIT};
                STEP_EMIT:     w = '{OP_EMIT,     COND_OUT_BLOCKED, STEP_EMIT};
                STEP_RETURN:   w = '{OP_NOP,      COND_ALWAYS,      STEP_WAIT};
                default:       w = '{OP_NOP,      COND_ALWAYS,      STEP_WAIT};
            endcase
            return w;
        end
    endfunction

endpackage

// File: rtl/core/ela_div.sv
// ----------------------------------------------------------------------------
// ela_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ela_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 9
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] dividend,
    input  logic [DEN_W-1:0] divisor,
    output logic             busy,
    output logic [NUM_W-1:0] quotient
);
    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;
    logic             fits;

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

    // shift in the next dividend bit and try the subtract
    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign fits    = (shifted >= {1'b0, den_reg});
    assign diff    = shifted - {1'b0, den_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        den_next = den_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            rem_next = '0;
            quo_next = dividend;
            den_next = divisor;
        end
        else if (busy)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
            rem_next = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            quo_next = {quo_reg[NUM_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

endmodule

// File: rtl/core/echo_level_averager.sv
// ----------------------------------------------------------------------------
// echo_level_averager
// ultrasonic echo width to distance, moving average over a ring of samples,
// liquid level and fill percentage, run by a small microcoded sequencer
// ----------------------------------------------------------------------------
//
//  channel  | signals                                         | direction
//  ---------+-------------------------------------------------+----------
//  input    | in_valid, in_ready, echo_us                     | in beat
//  output   | out_valid, out_ready, distance_q8, level_q8,    | out beat
//           | percent_q8, timed_out                           |
//  config   | cfg_we, cfg_index, cfg_data                     | write only
//
//  in_ready is high only at the wait step, so it stays low from the beat that
//  takes an echo until the sequencer is back there; a timeout echo skips the
//  clamp, ring and mean steps; both divisions (mean by fill count, percent by
//  tank height) go through one shared divider at one quotient bit per cycle
//  one echo is worked at a time; the result sits in an output register, so a
//  stalled out_ready only holds the sequencer at its emit step
//  reset sets the sequencer, registers and mean to their reset values and clears
//  the ring pointer, fill flag and sum; ring entries only leave the sum once the ring has filled
//
module echo_level_averager #(
    parameter int AVG_DEPTH = ela_pkg::AVG_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // input beats
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ela_pkg::ECHO_W-1:0]       echo_us,
    // output beats
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ela_pkg::DIST_W-1:0]       distance_q8,
    output logic [ela_pkg::DIST_W-1:0]       level_q8,
    output logic [ela_pkg::PCT_W-1:0]        percent_q8,
    output logic                             timed_out,
    // register writes
    input  logic                             cfg_we,
    input  logic [ela_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ela_pkg::CFG_W-1:0]        cfg_data
);
    import ela_pkg::*;

    // ring and divider sizing
    localparam int SLOT_W  = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
    localparam int SUM_W   = DIST_W + $clog2(AVG_DEPTH);
    localparam int FILL_W  = $clog2(AVG_DEPTH + 1);
    localparam int DEN_W   = (FILL_W > TANK_W) ? FILL_W : TANK_W;
    localparam int NUM_W   = (SUM_W > PCT_PROD_W) ? SUM_W : PCT_PROD_W;

    // sequencer
    pc_t    pc_reg, pc_next;
    uword_t uw;
    logic   cond_hit;

    // configuration
    logic [TANK_W-1:0] tank_reg, tank_next;
    logic [OFFS_W-1:0] offs_reg, offs_next;

    // averaging state
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              full_reg, full_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [DIST_W-1:0] mean_reg, mean_next;

    // working registers
    logic [ECHO_W-1:0]     echo_reg, echo_next;
    logic                  tmo_reg, tmo_next;
    logic [PROD_W-1:0]     prod_reg, prod_next;
    logic [DIST_W-1:0]     samp_reg, samp_next;
    logic [DIST_W-1:0]     rd_reg;
    logic [DIST_W-1:0]     lvl_reg, lvl_next;
    logic [PCT_PROD_W-1:0] pprod_reg, pprod_next;
    logic [PCT_W-1:0]      pct_reg, pct_next;

    // output register
    logic              ovld_reg, ovld_next;
    logic [DIST_W-1:0] odist_reg, odist_next;
    logic [DIST_W-1:0] olvl_reg, olvl_next;
    logic [PCT_W-1:0]  opct_reg, opct_next;
    logic              otmo_reg, otmo_next;

    // sample ring
    logic [DIST_W-1:0] ring_mem [AVG_DEPTH];

    // datapath signals
    logic                  in_beat;
    logic                  out_blocked;
    logic                  emit_fire;
    logic                  div_start;
    logic                  div_busy;
    logic [NUM_W-1:0]      div_num;
    logic [DEN_W-1:0]      div_den;
    logic [NUM_W-1:0]      div_quo;
    logic [DEN_W-1:0]      fill_cnt;
    logic [TANK_W:0]       span_cm;
    logic [SPAN_W-1:0]     span_q8;
    logic [DIST_W-1:0]     clamp_lim;
    logic [RAW_W-1:0]      dist_raw;
    logic [SPAN_W-1:0]     mean_ext;
    logic [SPAN_W-1:0]     span_diff;
    logic [DIST_W-1:0]     tank_q8;

    assign uw          = ucode_rom(pc_reg);
    assign in_ready    = (uw.op == OP_WAIT);
    assign in_beat     = in_valid && in_ready;
    assign out_blocked = ovld_reg && !out_ready;
    assign emit_fire   = (uw.op == OP_EMIT) && !out_blocked;

    assign out_valid   = ovld_reg;
    assign distance_q8 = odist_reg;
    assign level_q8    = olvl_reg;
    assign percent_q8  = opct_reg;
    assign timed_out   = otmo_reg;

    // ---------------------------------------------------------------- sequencer
    always_comb
    begin
        case (uw.cond)
            COND_NEXT:        cond_hit = 1'b0;
            COND_ALWAYS:      cond_hit = 1'b1;
            COND_NO_BEAT:     cond_hit = !in_beat;
            COND_TIMEOUT:     cond_hit = tmo_reg;
            COND_DIV_BUSY:    cond_hit = div_busy;
            COND_OUT_BLOCKED: cond_hit = out_blocked;
            default:          cond_hit = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next = cond_hit ? uw.target : pc_reg + pc_t'(1);
    end

    // ------------------------------------------------------- shared arithmetic
    // span of tank plus offset, q8; the distance clamp saturates at 17 bits
    assign span_cm   = {1'b0, tank_reg} + (TANK_W + 1)'(offs_reg);
    assign span_q8   = {span_cm, 8'b0};
    assign clamp_lim = (span_q8 > SPAN_W'(DIST_MAX)) ? DIST_MAX : span_q8[DIST_W-1:0];
    assign dist_raw  = prod_reg[PROD_W-1:US_SHIFT];
    assign mean_ext  = SPAN_W'(mean_reg);
    assign span_diff = span_q8 - mean_ext;
    assign tank_q8   = {tank_reg, 8'b0};

    // entries held after this sample went in
    assign fill_cnt  = full_reg ? DEN_W'(AVG_DEPTH) : DEN_W'(slot_reg);

    // divider operands chosen by the control word
    assign div_start = (uw.op == OP_DIV_MEAN) || (uw.op == OP_DIV_PCT);
    assign div_num   = (uw.op == OP_DIV_PCT) ? NUM_W'(pprod_reg) : NUM_W'(sum_reg);
    assign div_den   = (uw.op == OP_DIV_PCT) ? DEN_W'(tank_reg) : fill_cnt;

    ela_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // ---------------------------------------------------------------- datapath
    always_comb
    begin
        tank_next  = tank_reg;
        offs_next  = offs_reg;
        slot_next  = slot_reg;
        full_next  = full_reg;
        sum_next   = sum_reg;
        mean_next  = mean_reg;
        echo_next  = echo_reg;
        tmo_next   = tmo_reg;
        prod_next  = prod_reg;
        samp_next  = samp_reg;
        lvl_next   = lvl_reg;
        pprod_next = pprod_reg;
        pct_next   = pct_reg;

        // the user must write registers only while idle; the block does not enforce it
        if (cfg_we)
        begin
            case (cfg_index)
                REG_TANK_HEIGHT:   tank_next = cfg_data[TANK_W-1:0];
                REG_SENSOR_OFFSET: offs_next = cfg_data[OFFS_W-1:0];
                default:           tank_next = tank_reg;
            endcase
        end

        case (uw.op)
            OP_WAIT:
            begin
                if (in_beat)
                begin
                    echo_next = echo_us;
                    tmo_next  = (echo_us == '0);
                end
            end
            OP_MUL:
            begin
                prod_next = PROD_W'(echo_reg) * PROD_W'(US_TO_Q8_MUL);
            end
            OP_CLAMP:
            begin
                samp_next = (dist_raw > RAW_W'(clamp_lim)) ? clamp_lim
                                                           : dist_raw[DIST_W-1:0];
            end
            OP_ACCUM:
            begin
                // drop the oldest entry once the ring has wrapped
                sum_next = sum_reg - (full_reg ? SUM_W'(rd_reg) : SUM_W'(0))
                           + SUM_W'(samp_reg);
                if (slot_reg == SLOT_W'(AVG_DEPTH - 1))
                begin
                    slot_next = '0;
                    full_next = 1'b1;
                end
                else
                begin
                    slot_next = slot_reg + SLOT_W'(1);
                end
            end
            OP_MEAN:
            begin
                mean_next = div_quo[DIST_W-1:0];
            end
            OP_LEVEL:
            begin
                // level from the held mean, clamped to 0..tank
                if (mean_ext > span_q8)
                    lvl_next = '0;
                else if (span_diff > SPAN_W'(tank_q8))
                    lvl_next = tank_q8;
                else
                    lvl_next = span_diff[DIST_W-1:0];
            end
            OP_MUL_PCT:
            begin
                pprod_next = PCT_PROD_W'(lvl_reg) * PCT_PROD_W'(PCT_SCALE);
            end
            OP_PCT:
            begin
                // empty tank height reads as zero percent
                if (tank_reg == '0)
                    pct_next = '0;
                else if (div_quo > NUM_W'(PCT_MAX))
                    pct_next = PCT_MAX;
                else
                    pct_next = div_quo[PCT_W-1:0];
            end
            default:
            begin
                tmo_next = tmo_reg;
            end
        endcase
    end

    // ---------------------------------------------------------- output register
    always_comb
    begin
        ovld_next  = ovld_reg;
        odist_next = odist_reg;
        olvl_next  = olvl_reg;
        opct_next  = opct_reg;
        otmo_next  = otmo_reg;
        if (emit_fire)
        begin
            ovld_next  = 1'b1;
            odist_next = mean_reg;
            olvl_next  = lvl_reg;
            opct_next  = pct_reg;
            otmo_next  = tmo_reg;
        end
        else if (ovld_reg && out_ready)
        begin
            ovld_next = 1'b0;
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg   <= STEP_WAIT;
            tank_reg <= TANK_RESET;
            offs_reg <= OFFS_RESET;
            slot_reg <= '0;
            full_reg <= 1'b0;
            sum_reg  <= '0;
            mean_reg <= MEAN_RESET;
            ovld_reg <= 1'b0;
        end
        else
        begin
            pc_reg   <= pc_next;
            tank_reg <= tank_next;
            offs_reg <= offs_next;
            slot_reg <= slot_next;
            full_reg <= full_next;
            sum_reg  <= sum_next;
            mean_reg <= mean_next;
            ovld_reg <= ovld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        echo_reg  <= echo_next;
        tmo_reg   <= tmo_next;
        prod_reg  <= prod_next;
        samp_reg  <= samp_next;
        lvl_reg   <= lvl_next;
        pprod_reg <= pprod_next;
        pct_reg   <= pct_next;
        odist_reg <= odist_next;
        olvl_reg  <= olvl_next;
        opct_reg  <= opct_next;
        otmo_reg  <= otmo_next;
    end

    // ring: oldest entry read ahead of the store into the same slot
    always_ff @(posedge clk)
    begin
        if (uw.op == OP_MUL)
            rd_reg <= ring_mem[slot_reg];
        if (uw.op == OP_ACCUM)
            ring_mem[slot_reg] <= samp_reg;
    end

endmodule

// File: rtl/core/ela_checker.sv
// ----------------------------------------------------------------------------
// ela_checker
// port-level checks for the echo level averager, bound to the top level
// ----------------------------------------------------------------------------
module ela_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [ela_pkg::ECHO_W-1:0]    echo_us,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [ela_pkg::DIST_W-1:0]    distance_q8,
    input  logic [ela_pkg::DIST_W-1:0]    level_q8,
    input  logic [ela_pkg::PCT_W-1:0]     percent_q8,
    input  logic                          timed_out
);
    import ela_pkg::*;

    // one echo in flight: an accepted beat closes the input side
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input accepted again right after a beat");

    // a waiting input beat holds its payload
    a_in_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && !in_ready) |=> (in_valid && $stable(echo_us))
    ) else $error("waiting input beat changed");

    // percentage stays within full scale
    a_pct_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> (percent_q8 <= PCT_MAX)
    ) else $error("percent above full scale");

    // a stalled result holds
    a_out_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(distance_q8)
            && $stable(level_q8) && $stable(percent_q8) && $stable(timed_out))
    ) else $error("stalled result changed");

endmodule

bind echo_level_averager ela_checker u_ela_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .echo_us     (echo_us),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .distance_q8 (distance_q8),
    .level_q8    (level_q8),
    .percent_q8  (percent_q8),
    .timed_out   (timed_out)
);
